### sv/ghtc_pkg.sv
package ghtc_pkg;

    localparam int FRACTION_BITS_DEF = 4;

    // Fixed point width wide enough for 360 degrees at the default four fraction bits plus a rate step
    localparam int ANG_W    = 20;
    localparam int DIV_W    = 16;
    localparam int TIME_W   = 17;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [DIV_W-1:0]  DIVIDEND_MS = 16'd1000;
    localparam logic [15:0]       SHORT_GAP   = 16'd10;
    localparam logic [TIME_W-1:0] TIME_MAX    = 17'h1FFFF;

    localparam logic [12:0] TARGET_RST  = 13'd0;
    localparam logic [10:0] TOL_RST     = 11'd160;
    localparam logic [15:0] TIMEOUT_RST = 16'd30000;
    localparam logic [11:0] THR_RST     = 12'd16;

    localparam logic [1:0] REG_TARGET  = 2'd0;
    localparam logic [1:0] REG_TOL     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_THR     = 2'd3;

    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        KIND_IDLE    = 3'd0,
        KIND_TURNING = 3'd1,
        KIND_ARRIVED = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_SKIPPED = 3'd4
    } result_kind_t;

    typedef enum logic [2:0] {
        LATCH_NONE       = 3'd0,
        LATCH_RIGHT_FAR  = 3'd1,
        LATCH_LEFT_FAR   = 3'd2,
        LATCH_RIGHT_NEAR = 3'd3,
        LATCH_LEFT_NEAR  = 3'd4
    } latch_t;

    typedef enum logic [1:0] {
        BAND_100 = 2'd0,
        BAND_125 = 2'd1,
        BAND_150 = 2'd2
    } band_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV1,
        ST_DIV2,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [12:0] target_heading;
        logic [10:0] arrive_tolerance;
        logic [15:0] turn_timeout_ms;
        logic [11:0] rate_threshold;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_second;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_begin;
        logic is_short;
        logic over_thr;
        logic div_done;
        logic quot_zero;
        logic out_free;
    } status_t;

    function automatic logic signed [15:0] sat16(input logic signed [ANG_W-1:0] v);
        logic signed [15:0] r;
        if (v > ANG_W'(32767)) begin
            r = 16'sh7FFF;
        end
        else if (v < -ANG_W'(32768)) begin
            r = 16'sh8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### sv/ghtc_if.sv
interface ghtc_sample_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] gyro_rate;
    logic        [15:0] elapsed_ms;

    modport source (output valid, output operation, output gyro_rate, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input operation, input gyro_rate, input elapsed_ms,
                    output ready);
endinterface

interface ghtc_result_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  result_kind;
    logic signed [15:0] heading;
    logic               steer_right;
    logic        [1:0]  speed_band;

    modport source (output valid, output result_kind, output heading, output steer_right,
                    output speed_band, input ready);
    modport sink   (input valid, input result_kind, input heading, input steer_right,
                    input speed_band, output ready);
endinterface

### sv/ghtc_regs.sv
module ghtc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ghtc_pkg::CFG_AW-1:0] paddr,
    input  logic [ghtc_pkg::CFG_DW-1:0] pwdata,
    output logic [ghtc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output ghtc_pkg::cfg_t              cfg
);

    ghtc_pkg::cfg_t cfg_reg;
    ghtc_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ghtc_pkg::REG_TARGET:  cfg_next.target_heading   = pwdata[12:0];
                ghtc_pkg::REG_TOL:     cfg_next.arrive_tolerance = pwdata[10:0];
                ghtc_pkg::REG_TIMEOUT: cfg_next.turn_timeout_ms  = pwdata[15:0];
                ghtc_pkg::REG_THR:     cfg_next.rate_threshold   = pwdata[11:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ghtc_pkg::REG_TARGET:  prdata = {19'd0, cfg_reg.target_heading};
            ghtc_pkg::REG_TOL:     prdata = {21'd0, cfg_reg.arrive_tolerance};
            ghtc_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_reg.turn_timeout_ms};
            ghtc_pkg::REG_THR:     prdata = {20'd0, cfg_reg.rate_threshold};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_heading   <= ghtc_pkg::TARGET_RST;
            cfg_reg.arrive_tolerance <= ghtc_pkg::TOL_RST;
            cfg_reg.turn_timeout_ms  <= ghtc_pkg::TIMEOUT_RST;
            cfg_reg.rate_threshold   <= ghtc_pkg::THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/ghtc_div.sv
module ghtc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ghtc_pkg::DIV_W-1:0] dividend,
    input  logic [ghtc_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [ghtc_pkg::DIV_W-1:0] quotient
);

    localparam int W     = ghtc_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring step: shift in the next dividend bit, subtract if it fits
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

### sv/ghtc_datapath.sv
module ghtc_datapath #(
    parameter int FRACTION_BITS = ghtc_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ghtc_pkg::cfg_t      cfg,
    input  ghtc_pkg::cmd_t      cmd,
    output ghtc_pkg::status_t   status,
    input  logic                operation,
    input  logic signed [15:0]  gyro_rate,
    input  logic        [15:0]  elapsed_ms,
    input  logic                out_ready,
    output logic                out_valid,
    output logic        [2:0]   result_kind,
    output logic signed [15:0]  heading,
    output logic                steer_right,
    output logic        [1:0]   speed_band
);

    localparam int AW = ghtc_pkg::ANG_W;
    localparam int TW = ghtc_pkg::TIME_W;
    localparam int DW = ghtc_pkg::DIV_W;

    localparam logic signed [AW-1:0] A360 = AW'(360 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A359 = AW'(359 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A180 = AW'(180 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A350 = AW'(350 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A340 = AW'(340 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A20  = AW'(20 << FRACTION_BITS);
    localparam logic signed [AW-1:0] A10  = AW'(10 << FRACTION_BITS);
    localparam logic signed [15:0]   HEADING_RST = ghtc_pkg::sat16(A360);

    // captured item
    logic               op_reg;
    logic               neg_reg;
    logic [15:0]        mag_reg;
    logic [15:0]        gap_reg;

    // block state
    logic signed [15:0]     yaw_reg, yaw_next;
    logic signed [15:0]     heading_reg, heading_next;
    ghtc_pkg::latch_t       latch_reg, latch_next;
    logic                   active_reg, active_next;
    logic [TW-1:0]          tt_reg, tt_next;

    // result word
    logic                   out_valid_reg, out_valid_next;
    ghtc_pkg::result_kind_t kind_reg, kind_next;
    logic signed [15:0]     out_heading_reg;
    logic                   right_reg, right_next;
    ghtc_pkg::band_t        band_reg, band_next;

    logic [DW-1:0]          div_dividend, div_divisor, div_quot;
    logic                   div_done;

    logic signed [AW-1:0]   delta, yaw_sum, yaw_wrap;
    logic signed [AW-1:0]   hdg_w, diff, win_lo, win_hi;
    logic                   in_win;
    logic [TW:0]            tt_sum;
    logic [TW-1:0]          tt_sat;
    ghtc_pkg::latch_t       st_latch;
    logic                   st_right;
    ghtc_pkg::band_t        st_band;

    assign div_dividend = cmd.div_second ? mag_reg : ghtc_pkg::DIVIDEND_MS;
    assign div_divisor  = cmd.div_second ? div_quot : gap_reg;

    ghtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign status.is_begin  = (op_reg == ghtc_pkg::OP_BEGIN);
    assign status.is_short  = (gap_reg <= ghtc_pkg::SHORT_GAP);
    assign status.over_thr  = (mag_reg > {4'd0, cfg.rate_threshold});
    assign status.div_done  = div_done;
    assign status.quot_zero = (div_quot == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    // yaw integration; below threshold adds nothing but still wraps
    always_comb
    begin
        if (status.over_thr)
        begin
            delta = neg_reg ? -$signed(AW'(div_quot)) : $signed(AW'(div_quot));
        end
        else
        begin
            delta = '0;
        end
        yaw_sum = AW'(yaw_reg) + delta;
        if (yaw_sum < 0)
        begin
            yaw_wrap = yaw_sum + A360;
        end
        else if (yaw_sum > A359)
        begin
            yaw_wrap = yaw_sum - A360;
        end
        else
        begin
            yaw_wrap = yaw_sum;
        end
        yaw_next     = yaw_reg;
        heading_next = heading_reg;
        if (cmd.update)
        begin
            yaw_next     = ghtc_pkg::sat16(yaw_wrap);
            heading_next = ghtc_pkg::sat16(A360 - AW'(yaw_next));
        end
    end

    assign hdg_w  = AW'(heading_reg);
    assign win_lo = $signed(AW'(cfg.target_heading)) - $signed(AW'(cfg.arrive_tolerance));
    assign win_hi = $signed(AW'(cfg.target_heading)) + $signed(AW'(cfg.arrive_tolerance));
    assign in_win = (hdg_w >= win_lo) && (hdg_w <= win_hi);
    assign diff   = hdg_w - $signed(AW'(cfg.target_heading));
    assign tt_sum = {1'b0, tt_reg} + (TW + 1)'(gap_reg);
    assign tt_sat = tt_sum[TW] ? ghtc_pkg::TIME_MAX : tt_sum[TW-1:0];

    // sticky shortest-direction choice
    always_comb
    begin
        st_latch = latch_reg;
        st_right = 1'b0;
        st_band  = ghtc_pkg::BAND_100;
        if (diff > A180 || latch_reg == ghtc_pkg::LATCH_RIGHT_FAR)
        begin
            st_latch = ghtc_pkg::LATCH_RIGHT_FAR;
            st_right = 1'b1;
            st_band  = (diff > A350) ? ghtc_pkg::BAND_150 :
                       (diff > A340) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
        end
        else if (diff < -A180 || latch_reg == ghtc_pkg::LATCH_LEFT_FAR)
        begin
            st_latch = ghtc_pkg::LATCH_LEFT_FAR;
            st_band  = (diff < -A350) ? ghtc_pkg::BAND_150 :
                       (diff < -A340) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
        end
        else if (diff < 0 || latch_reg == ghtc_pkg::LATCH_RIGHT_NEAR)
        begin
            st_latch = ghtc_pkg::LATCH_RIGHT_NEAR;
            st_right = 1'b1;
            st_band  = (diff > -A10) ? ghtc_pkg::BAND_150 :
                       (diff > -A20) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
        end
        else if (diff > 0 || latch_reg == ghtc_pkg::LATCH_LEFT_NEAR)
        begin
            st_latch = ghtc_pkg::LATCH_LEFT_NEAR;
            st_band  = (diff < A10) ? ghtc_pkg::BAND_150 :
                       (diff < A20) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
        end
    end

    always_comb
    begin
        latch_next     = latch_reg;
        active_next    = active_reg;
        tt_next        = tt_reg;
        kind_next      = kind_reg;
        right_next     = right_reg;
        band_next      = band_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            kind_next      = ghtc_pkg::KIND_IDLE;
            right_next     = 1'b0;
            band_next      = ghtc_pkg::BAND_100;
            if (status.is_begin)
            begin
                tt_next    = '0;
                latch_next = ghtc_pkg::LATCH_NONE;
                if (in_win)
                begin
                    active_next = 1'b0;
                    kind_next   = ghtc_pkg::KIND_ARRIVED;
                end
                else
                begin
                    active_next = 1'b1;
                    kind_next   = ghtc_pkg::KIND_TURNING;
                end
            end
            else if (status.is_short)
            begin
                kind_next = ghtc_pkg::KIND_SKIPPED;
            end
            else if (active_reg)
            begin
                tt_next = tt_sat;
                if (in_win)
                begin
                    active_next = 1'b0;
                    kind_next   = ghtc_pkg::KIND_ARRIVED;
                end
                else if (tt_sat >= TW'(cfg.turn_timeout_ms))
                begin
                    active_next = 1'b0;
                    kind_next   = ghtc_pkg::KIND_TIMEOUT;
                end
                else
                begin
                    kind_next  = ghtc_pkg::KIND_TURNING;
                    latch_next = st_latch;
                    right_next = st_right;
                    band_next  = st_band;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            neg_reg <= gyro_rate[15];
            mag_reg <= gyro_rate[15] ? 16'(-gyro_rate) : gyro_rate;
            gap_reg <= elapsed_ms;
        end
        if (cmd.finish)
        begin
            out_heading_reg <= heading_reg;
        end
        kind_reg  <= kind_next;
        right_reg <= right_next;
        band_reg  <= band_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg       <= '0;
            heading_reg   <= HEADING_RST;
            latch_reg     <= ghtc_pkg::LATCH_NONE;
            active_reg    <= 1'b0;
            tt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            yaw_reg       <= yaw_next;
            heading_reg   <= heading_next;
            latch_reg     <= latch_next;
            active_reg    <= active_next;
            tt_reg        <= tt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign heading     = out_heading_reg;
    assign steer_right = right_reg;
    assign speed_band  = band_reg;

endmodule

### sv/ghtc_ctrl.sv
module ghtc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ghtc_pkg::status_t status,
    output ghtc_pkg::cmd_t    cmd
);

    ghtc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghtc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ghtc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ghtc_pkg::ST_LOAD;
                end
            end
            ghtc_pkg::ST_LOAD:
            begin
                if (status.is_begin || status.is_short)
                begin
                    state_next = ghtc_pkg::ST_FINISH;
                end
                else if (!status.over_thr)
                begin
                    state_next = ghtc_pkg::ST_UPDATE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ghtc_pkg::ST_DIV1;
                end
            end
            ghtc_pkg::ST_DIV1:
            begin
                if (status.div_done)
                begin
                    if (status.quot_zero)
                    begin
                        // drop the yaw update, the sample still counts as turn time
                        state_next = ghtc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cmd.div_start  = 1'b1;
                        cmd.div_second = 1'b1;
                        state_next     = ghtc_pkg::ST_DIV2;
                    end
                end
            end
            ghtc_pkg::ST_DIV2:
            begin
                if (status.div_done)
                begin
                    state_next = ghtc_pkg::ST_UPDATE;
                end
            end
            ghtc_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ghtc_pkg::ST_FINISH;
            end
            ghtc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ghtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghtc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/gyro_heading_turn_controller.sv
// Sequence: a begin item or a short-gap sample goes from LOAD straight to FINISH, a sample
// under the rate threshold passes through UPDATE, an over-threshold sample with a gap past
// one second stops after the first divider pass; a sample that integrates makes two 16-step
// passes through the shared restoring divider (1000/gap, then rate/quotient).
// One item at a time; the next is taken once the word is loaded and the control is back in IDLE.
// Reset (rst_n, async, active low): yaw 0, heading 360 degrees, no turn, registers at defaults.
module gyro_heading_turn_controller #(
    parameter int FRACTION_BITS = ghtc_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ghtc_sample_if.sink                 sample_ch,
    ghtc_result_if.source               result_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ghtc_pkg::CFG_AW-1:0] paddr,
    input  logic [ghtc_pkg::CFG_DW-1:0] pwdata,
    output logic [ghtc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    ghtc_pkg::cfg_t    cfg;
    ghtc_pkg::cmd_t    cmd;
    ghtc_pkg::status_t status;

    ghtc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ghtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ghtc_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .operation   (sample_ch.operation),
        .gyro_rate   (sample_ch.gyro_rate),
        .elapsed_ms  (sample_ch.elapsed_ms),
        .out_ready   (result_ch.ready),
        .out_valid   (result_ch.valid),
        .result_kind (result_ch.result_kind),
        .heading     (result_ch.heading),
        .steer_right (result_ch.steer_right),
        .speed_band  (result_ch.speed_band)
    );

endmodule

### sv/ghtc_checker.sv
module ghtc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        result_kind,
    input logic signed [15:0] heading,
    input logic              steer_right,
    input logic [1:0]        speed_band
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(heading)
            && $stable(steer_right) && $stable(speed_band))
        else $error("result word changed while stalled");

    // one item in flight: no new sample right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind <= ghtc_pkg::KIND_SKIPPED && speed_band != 2'd3)
        else $error("illegal result kind or speed band");

    a_dir_only_turning: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != ghtc_pkg::KIND_TURNING |-> !steer_right && speed_band == 2'd0)
        else $error("direction fields set outside a turning result");

endmodule

bind gyro_heading_turn_controller ghtc_checker u_ghtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .result_kind (result_ch.result_kind),
    .heading     (result_ch.heading),
    .steer_right (result_ch.steer_right),
    .speed_band  (result_ch.speed_band)
);

### bench/gyro_heading_turn_controller_test.sv
module gyro_heading_turn_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_DEG = 1 << ghtc_pkg::FRACTION_BITS_DEF;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] heading;
        logic               steer_right;
        logic [1:0]         band;
    } turn_word_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ghtc_pkg::CFG_AW-1:0]  paddr;
    logic [ghtc_pkg::CFG_DW-1:0]  pwdata;
    logic [ghtc_pkg::CFG_DW-1:0]  prdata;
    logic                         pready;

    ghtc_sample_if sample_ch ();
    ghtc_result_if result_ch ();

    gyro_heading_turn_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // heading model state and register copies
    int               yaw_q;
    int               hdg_q;
    ghtc_pkg::latch_t latch_q;
    bit               turning_q;
    int unsigned      turn_ms_q;
    logic [12:0]      cfg_target;
    logic [10:0]      cfg_tol;
    logic [15:0]      cfg_timeout;
    logic [11:0]      cfg_thr;

    turn_word_t  words_due[$];
    int          error_count;
    bit          idle_on;
    int          stall_cnt;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clip16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic bit heading_in_window();
        return hdg_q >= int'(cfg_target) - int'(cfg_tol)
            && hdg_q <= int'(cfg_target) + int'(cfg_tol);
    endfunction

    function automatic turn_word_t compute_turn_word(input logic op,
                                                     input logic signed [15:0] rate,
                                                     input logic [15:0] gap);
        turn_word_t w;
        int         tmp;
        int         mag;
        int         q;
        int         d;
        bit         hold_yaw;
        w.kind        = ghtc_pkg::KIND_IDLE;
        w.heading     = '0;
        w.steer_right = 1'b0;
        w.band        = ghtc_pkg::BAND_100;
        if (op == ghtc_pkg::OP_BEGIN)
        begin
            turn_ms_q = 0;
            latch_q   = ghtc_pkg::LATCH_NONE;
            turning_q = !heading_in_window();
            w.kind    = turning_q ? ghtc_pkg::KIND_TURNING : ghtc_pkg::KIND_ARRIVED;
        end
        else if (gap <= ghtc_pkg::SHORT_GAP)
        begin
            w.kind = ghtc_pkg::KIND_SKIPPED;
        end
        else
        begin
            tmp      = yaw_q;
            mag      = (rate < 0) ? -int'(rate) : int'(rate);
            hold_yaw = 1'b0;
            if (mag > int'(cfg_thr))
            begin
                // 1000/gap is zero past one second: drop the update
                if (gap > ghtc_pkg::DIVIDEND_MS)
                    hold_yaw = 1'b1;
                else
                begin
                    q = mag / (1000 / int'(gap));
                    tmp += (rate < 0) ? -q : q;
                end
            end
            if (!hold_yaw)
            begin
                if (tmp < 0)
                    tmp += 360 * ONE_DEG;
                else if (tmp > 359 * ONE_DEG)
                    tmp -= 360 * ONE_DEG;
                yaw_q = clip16(tmp);
                hdg_q = clip16(360 * ONE_DEG - yaw_q);
            end
            if (turning_q)
            begin
                turn_ms_q += gap;
                if (turn_ms_q > ghtc_pkg::TIME_MAX)
                    turn_ms_q = ghtc_pkg::TIME_MAX;
                if (heading_in_window())
                begin
                    turning_q = 1'b0;
                    w.kind    = ghtc_pkg::KIND_ARRIVED;
                end
                else if (turn_ms_q >= cfg_timeout)
                begin
                    turning_q = 1'b0;
                    w.kind    = ghtc_pkg::KIND_TIMEOUT;
                end
                else
                begin
                    // sticky shortest-direction choice
                    w.kind = ghtc_pkg::KIND_TURNING;
                    d = hdg_q - int'(cfg_target);
                    if (d > 180 * ONE_DEG || latch_q == ghtc_pkg::LATCH_RIGHT_FAR)
                    begin
                        latch_q       = ghtc_pkg::LATCH_RIGHT_FAR;
                        w.steer_right = 1'b1;
                        w.band = (d > 350 * ONE_DEG) ? ghtc_pkg::BAND_150 :
                                 (d > 340 * ONE_DEG) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
                    end
                    else if (d < -180 * ONE_DEG || latch_q == ghtc_pkg::LATCH_LEFT_FAR)
                    begin
                        latch_q = ghtc_pkg::LATCH_LEFT_FAR;
                        w.band = (d < -350 * ONE_DEG) ? ghtc_pkg::BAND_150 :
                                 (d < -340 * ONE_DEG) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
                    end
                    else if (d < 0 || latch_q == ghtc_pkg::LATCH_RIGHT_NEAR)
                    begin
                        latch_q       = ghtc_pkg::LATCH_RIGHT_NEAR;
                        w.steer_right = 1'b1;
                        w.band = (d > -10 * ONE_DEG) ? ghtc_pkg::BAND_150 :
                                 (d > -20 * ONE_DEG) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
                    end
                    else if (d > 0 || latch_q == ghtc_pkg::LATCH_LEFT_NEAR)
                    begin
                        latch_q = ghtc_pkg::LATCH_LEFT_NEAR;
                        w.band = (d < 10 * ONE_DEG) ? ghtc_pkg::BAND_150 :
                                 (d < 20 * ONE_DEG) ? ghtc_pkg::BAND_125 : ghtc_pkg::BAND_100;
                    end
                end
            end
        end
        w.heading = hdg_q[15:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    // result sink: random stall bursts
    always @(posedge clk)
    begin
        if (stall_cnt != 0)
            stall_cnt = stall_cnt - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_cnt = $urandom_range(1, 14);
        result_ch.ready <= (stall_cnt == 0);
    end

    always @(posedge clk)
    begin
        turn_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (words_due.size() == 0)
                report_mismatch("word with none due, kind", result_ch.result_kind, -1);
            else
            begin
                want = words_due.pop_front();
                if (result_ch.result_kind !== want.kind)
                    report_mismatch("result_kind", result_ch.result_kind, want.kind);
                if (result_ch.heading !== want.heading)
                    report_mismatch("heading", result_ch.heading, want.heading);
                if (result_ch.steer_right !== want.steer_right)
                    report_mismatch("steer_right", result_ch.steer_right, want.steer_right);
                if (result_ch.speed_band !== want.band)
                    report_mismatch("speed_band", result_ch.speed_band, want.band);
            end
        end
    end

    // valid stays high after acceptance; settle_block lowers it
    task automatic send_word(input logic op, input logic signed [15:0] rate,
                             input logic [15:0] gap);
        int n;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 14);
            sample_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.operation  <= op;
        sample_ch.gyro_rate  <= rate;
        sample_ch.elapsed_ms <= gap;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        words_due.push_back(compute_turn_word(op, rate, gap));
    endtask

    task automatic settle_block();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        case (idx)
            ghtc_pkg::REG_TARGET:
            begin
                cfg_target = value[12:0];
                want = {19'd0, value[12:0]};
            end
            ghtc_pkg::REG_TOL:
            begin
                cfg_tol = value[10:0];
                want = {21'd0, value[10:0]};
            end
            ghtc_pkg::REG_TIMEOUT:
            begin
                cfg_timeout = value[15:0];
                want = {16'd0, value[15:0]};
            end
            default:
            begin
                cfg_thr = value[11:0];
                want = {20'd0, value[11:0]};
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // go straight into a read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [12:0] target, input logic [10:0] tol,
                                  input logic [15:0] timeout, input logic [11:0] thr);
        write_reg(ghtc_pkg::REG_TARGET, {19'd0, target});
        write_reg(ghtc_pkg::REG_TOL, {21'd0, tol});
        write_reg(ghtc_pkg::REG_TIMEOUT, {16'd0, timeout});
        write_reg(ghtc_pkg::REG_THR, {20'd0, thr});
    endtask

    task automatic send_random_word();
        logic               op;
        logic signed [15:0] rate;
        logic [15:0]        gap;
        int                 near;
        op = ($urandom_range(0, 11) == 0) ? ghtc_pkg::OP_BEGIN : ghtc_pkg::OP_SAMPLE;
        case ($urandom_range(0, 19))
            0, 1:    gap = 16'($urandom_range(0, 10));
            2:       gap = 16'($urandom_range(1001, 65535));
            3:       gap = 16'($urandom);
            4, 5:    gap = 16'($urandom_range(201, 1000));
            default: gap = 16'($urandom_range(11, 200));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    rate = 16'($urandom);
            2, 3:
            begin
                near = int'(cfg_thr) + int'($urandom_range(0, 2)) - 1;
                rate = ($urandom_range(0, 1) == 0) ? 16'(near) : 16'(-near);
            end
            default: rate = 16'(int'($urandom_range(0, 4000)) - 2000);
        endcase
        send_word(op, rate, gap);
    endtask

    task automatic test_short_and_idle_samples();
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh7FFF, 16'd0);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh8000, 16'd10);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd16, 16'd11);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd17, 16'd11);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh8000, 16'hFFFF);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd0, 16'd1000);
    endtask

    task automatic test_turn_steering();
        send_word(ghtc_pkg::OP_BEGIN, 16'sd0, 16'd0);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd0, 16'd100);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd1600, 16'd100);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd3000, 16'd1000);
        send_word(ghtc_pkg::OP_BEGIN, 16'sh7FFF, 16'hFFFF);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd0, 16'd50);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd2500, 16'd500);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd1330, 16'd1000);
        send_word(ghtc_pkg::OP_BEGIN, 16'sd0, 16'd0);
    endtask

    task automatic test_zero_timeout();
        settle_block();
        write_settings(13'd2880, 11'd0, 16'd0, ghtc_pkg::THR_RST);
        send_word(ghtc_pkg::OP_BEGIN, 16'sd0, 16'd0);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd0, 16'd11);
        send_word(ghtc_pkg::OP_BEGIN, 16'sd0, 16'd0);
        // lands exactly on target: arrival wins over the zero limit
        send_word(ghtc_pkg::OP_SAMPLE, 16'sd2900, 16'd1000);
    endtask

    task automatic test_heading_saturation();
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh7FFF, 16'd1000);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh7FFF, 16'd1000);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh8000, 16'd1000);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh8000, 16'd1000);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh8000, 16'd1000);
        send_word(ghtc_pkg::OP_SAMPLE, 16'sh7FFF, 16'd1000);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++)
        begin
            settle_block();
            case (p)
                0:       write_settings(13'd0, 11'd0, 16'd1, 12'd0);
                1:       write_settings(13'd5760, 11'd1440, 16'hFFFF, 12'd4095);
                2:       write_settings(13'h1FFF, 11'h7FF, 16'd300, 12'd100);
                default: write_settings(($urandom_range(0, 3) == 0) ? 13'($urandom)
                                                                   : 13'($urandom_range(0, 5760)),
                                        11'($urandom_range(0, 400)),
                                        16'($urandom_range(50, 5000)),
                                        12'($urandom_range(0, 200)));
            endcase
            repeat (200) send_random_word();
        end
    endtask

    task automatic test_steady_stream();
        settle_block();
        idle_on = 1'b0;
        write_settings(13'($urandom_range(0, 5760)), 11'($urandom_range(40, 400)),
                       16'($urandom_range(200, 3000)), 12'($urandom_range(0, 64)));
        repeat (200) send_random_word();
        settle_block();
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.operation  = ghtc_pkg::OP_SAMPLE;
        sample_ch.gyro_rate  = '0;
        sample_ch.elapsed_ms = '0;
        result_ch.ready      = 1'b0;
        stall_cnt            = 0;
        error_count          = 0;
        idle_on              = 1'b1;
        cfg_target           = ghtc_pkg::TARGET_RST;
        cfg_tol              = ghtc_pkg::TOL_RST;
        cfg_timeout          = ghtc_pkg::TIMEOUT_RST;
        cfg_thr              = ghtc_pkg::THR_RST;
        yaw_q                = 0;
        hdg_q                = clip16(360 * ONE_DEG);
        latch_q              = ghtc_pkg::LATCH_NONE;
        turning_q            = 1'b0;
        turn_ms_q            = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_and_idle_samples();
        test_turn_steering();
        test_zero_timeout();
        test_heading_saturation();
        test_random_settings();
        test_steady_stream();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
